### src/i2cee_pkg.sv
// Package for the I2C EEPROM master: sequencer states, plan kinds, op codes.
// No dependencies.
`timescale 1ns / 1ps
package i2cee_pkg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_FETCH, ST_ST0, ST_ST1, ST_ST2, ST_ST3,
        ST_SP0, ST_SP1, ST_SP2, ST_SP3, ST_SB_A, ST_SB_B, ST_SB_C,
        ST_ACK_A, ST_ACK_B, ST_ACK_C, ST_RB_A, ST_RB_B, ST_RA_A, ST_RA_B, ST_RA_C
    } seq_state_t;

    typedef enum logic [2:0] {
        PK_START, PK_STOP, PK_SEND, PK_READ, PK_END
    } plan_kind_t;

    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_STOP     = 3'd1;
    localparam logic [2:0] OP_SEND     = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_EE_WRITE = 3'd4;
    localparam logic [2:0] OP_EE_READ  = 3'd5;
    localparam logic [2:0] OP_EE_BURST = 3'd6;
    localparam logic [2:0] OP_ILLEGAL  = 3'd7;

    localparam logic [1:0] CFG_DEVICE = 2'd0;
    localparam logic [1:0] CFG_PHASE  = 2'd1;
    localparam logic [1:0] CFG_SETUP  = 2'd2;
    localparam logic [1:0] CFG_STOP   = 2'd3;

    localparam int IN_W  = 48;
    localparam int OUT_W = 16;

endpackage

### src/i2c_master_eeprom_controller.sv
// I2C master sequencer for 24Cxx EEPROMs with a stream item port.
// Depends on i2cee_pkg.
// After acceptance an item's result passes through the registers in order
// (input register, then result register); throughput one item per cycle
// while the output is not stalled. Asynchronous active-low reset
// returns the sequencer to idle with both lines released and default registers.
`timescale 1ns / 1ps
module i2c_master_eeprom_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // op[2:0], data_byte[10:3], mem_address[26:11], byte_count[42:27],
    // ack_to_send[43], sda_in[44], zero fill
    input  logic [i2cee_pkg::IN_W-1:0]   s_tdata,
    input  logic                         s_tuser,   // func
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // scl_drive_low[0], sda_drive_low[1], busy_res[2], read_valid[3],
    // read_byte[11:4], ack_valid[12], ack_received[13], op_done[14], zero fill
    output logic [i2cee_pkg::OUT_W-1:0]  m_tdata,
    output logic                         m_tlast,   // last_byte
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [7:0]                   cfg_data
);
    import i2cee_pkg::*;

    // configuration
    logic [6:0] dev_reg;
    logic [7:0] phase_reg, setup_reg, stopt_reg;

    // input stage
    logic                in_valid_reg;
    logic [IN_W-1:0]     in_data_reg;
    logic                in_func_reg;

    // sequencer state
    seq_state_t  st_reg, st_next;
    logic [7:0]  pc_reg, pc_next;
    logic [3:0]  bc_reg, bc_next;
    logic [7:0]  sh_reg, sh_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] rem_reg, rem_next;
    logic [2:0]  op_reg, op_next;
    logic [1:0]  ld_reg, ld_next;
    logic [3:0]  pp_reg, pp_next;
    logic [7:0]  dh_reg, dh_next;
    logic        ah_reg, ah_next;
    logic        ab_reg, ab_next;

    // output stage
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;
    logic                out_last_reg;

    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // fields of the registered item
    logic [2:0]  f_op;
    logic [7:0]  f_data;
    logic [15:0] f_addr, f_cnt;
    logic        f_ack, f_sda;
    assign f_op   = in_data_reg[2:0];
    assign f_data = in_data_reg[10:3];
    assign f_addr = in_data_reg[26:11];
    assign f_cnt  = in_data_reg[42:27];
    assign f_ack  = in_data_reg[43];
    assign f_sda  = in_data_reg[44];

    // plan lookup
    plan_kind_t kind;
    logic [7:0] arg;
    always_comb
    begin
        kind = PK_END;
        arg  = 8'd0;
        case (op_reg)
            OP_START: kind = (pp_reg == 4'd0) ? PK_START : PK_END;
            OP_STOP:  kind = (pp_reg == 4'd0) ? PK_STOP : PK_END;
            OP_SEND:
            begin
                arg  = dh_reg;
                kind = (pp_reg == 4'd0) ? PK_SEND : PK_END;
            end
            OP_READ:
            begin
                arg  = {7'd0, ah_reg};
                kind = (pp_reg == 4'd0) ? PK_READ : PK_END;
            end
            OP_EE_WRITE:
            begin
                case (pp_reg)
                    4'd0, 4'd6: kind = PK_START;
                    4'd1, 4'd7: begin kind = PK_SEND; arg = {dev_reg, 1'b0}; end
                    4'd2: begin kind = PK_SEND; arg = addr_reg[15:8]; end
                    4'd3: begin kind = PK_SEND; arg = addr_reg[7:0]; end
                    4'd4: begin kind = PK_SEND; arg = dh_reg; end
                    4'd5, 4'd8: kind = PK_STOP;
                    default: kind = PK_END;
                endcase
            end
            OP_EE_READ, OP_EE_BURST:
            begin
                case (pp_reg)
                    4'd0, 4'd4: kind = PK_START;
                    4'd1: begin kind = PK_SEND; arg = {dev_reg, 1'b0}; end
                    4'd2: begin kind = PK_SEND; arg = addr_reg[15:8]; end
                    4'd3: begin kind = PK_SEND; arg = addr_reg[7:0]; end
                    4'd5: begin kind = PK_SEND; arg = {dev_reg, 1'b1}; end
                    4'd6:
                    begin
                        kind = PK_READ;
                        arg  = {7'd0, (op_reg == OP_EE_READ) || (rem_reg <= 16'd1)};
                    end
                    4'd7: kind = PK_STOP;
                    default: kind = PK_END;
                endcase
            end
            default: kind = PK_END;
        endcase
    end

    function automatic logic [7:0] cnt1(input logic [7:0] t);
        return (t == 8'd0) ? 8'd0 : t - 8'd1;
    endfunction

    // sequencer step
    logic       o_rv, o_av, o_ar, o_done, o_last;
    logic [7:0] o_rb;
    seq_state_t s;
    logic       nextp;
    always_comb
    begin
        st_next = st_reg; pc_next = pc_reg; bc_next = bc_reg; sh_next = sh_reg;
        addr_next = addr_reg; rem_next = rem_reg; op_next = op_reg; ld_next = ld_reg;
        pp_next = pp_reg; dh_next = dh_reg; ah_next = ah_reg; ab_next = ab_reg;
        o_rv = 1'b0; o_rb = 8'd0; o_av = 1'b0; o_ar = 1'b0; o_done = 1'b0;
        o_last = 1'b0; nextp = 1'b0; s = st_reg;
        if (in_func_reg)
        begin
            if (st_reg == ST_IDLE && f_op != OP_ILLEGAL)
            begin
                op_next = f_op; dh_next = f_data; addr_next = f_addr;
                rem_next = (f_cnt == 16'd0) ? 16'd1 : f_cnt;
                ah_next = f_ack; pp_next = 4'd0; pc_next = 8'd0; bc_next = 4'd0;
                st_next = ST_FETCH;
            end
        end
        else if (st_reg != ST_IDLE)
        begin
            if (pc_reg != 8'd0)
                pc_next = pc_reg - 8'd1;
            else
            begin
                if (st_reg == ST_FETCH)
                begin
                    bc_next = 4'd0;
                    case (kind)
                        PK_START: s = ST_ST0;
                        PK_STOP:  s = ST_SP0;
                        PK_SEND:  begin sh_next = arg; s = ST_SB_A; end
                        PK_READ:  begin sh_next = 8'd0; s = ST_RB_A; end
                        default:  begin s = ST_IDLE; o_done = 1'b1; end
                    endcase
                end
                st_next = s;
                case (s)
                    ST_ST0:
                    begin
                        ld_next = {ld_reg[1], 1'b0}; pc_next = cnt1(phase_reg);
                        st_next = ST_ST1;
                    end
                    ST_ST1:
                    begin
                        ld_next = {1'b0, ld_reg[0]}; pc_next = cnt1(phase_reg);
                        st_next = ST_ST2;
                    end
                    ST_ST2:
                    begin
                        ld_next = {1'b1, ld_reg[0]}; pc_next = cnt1(phase_reg);
                        st_next = ST_ST3;
                    end
                    ST_ST3:
                    begin
                        ld_next = {ld_reg[1], 1'b1}; pc_next = cnt1(phase_reg);
                        nextp = 1'b1;
                    end
                    ST_SP0:
                    begin
                        ld_next = {1'b1, ld_reg[0]}; pc_next = cnt1(stopt_reg);
                        st_next = ST_SP1;
                    end
                    ST_SP1:
                    begin
                        ld_next = {ld_reg[1], 1'b1}; pc_next = cnt1(stopt_reg);
                        st_next = ST_SP2;
                    end
                    ST_SP2:
                    begin
                        ld_next = {ld_reg[1], 1'b0}; pc_next = cnt1(stopt_reg);
                        st_next = ST_SP3;
                    end
                    ST_SP3:
                    begin
                        ld_next = {1'b0, ld_reg[0]}; pc_next = cnt1(stopt_reg);
                        nextp = 1'b1;
                    end
                    ST_SB_A:
                    begin
                        ld_next = 2'b01; pc_next = cnt1(setup_reg);
                        st_next = ST_SB_B;
                    end
                    ST_SB_B:
                    begin
                        ld_next = {~sh_next[7], ld_reg[0]};
                        pc_next = cnt1(phase_reg); st_next = ST_SB_C;
                    end
                    ST_SB_C:
                    begin
                        ld_next = {ld_reg[1], 1'b0}; pc_next = cnt1(phase_reg);
                        sh_next = {sh_reg[6:0], 1'b0};
                        bc_next = bc_reg + 4'd1;
                        st_next = (bc_reg + 4'd1 >= 4'd8) ? ST_ACK_A : ST_SB_A;
                    end
                    ST_ACK_A:
                    begin
                        ld_next = 2'b01; pc_next = cnt1(phase_reg);
                        st_next = ST_ACK_B;
                    end
                    ST_ACK_B:
                    begin
                        ld_next = {ld_reg[1], 1'b0}; pc_next = cnt1(phase_reg);
                        ab_next = f_sda; st_next = ST_ACK_C;
                    end
                    ST_ACK_C:
                    begin
                        ld_next = 2'b01; pc_next = 8'd0;
                        o_av = 1'b1; o_ar = ab_reg; nextp = 1'b1;
                    end
                    ST_RB_A:
                    begin
                        ld_next = 2'b01; pc_next = cnt1(phase_reg);
                        st_next = ST_RB_B;
                    end
                    ST_RB_B:
                    begin
                        ld_next = {ld_reg[1], 1'b0}; pc_next = cnt1(phase_reg);
                        sh_next = {sh_next[6:0], f_sda};
                        bc_next = bc_reg + 4'd1;
                        st_next = (bc_reg + 4'd1 >= 4'd8) ? ST_RA_A : ST_RB_A;
                    end
                    ST_RA_A:
                    begin
                        ld_next = {~arg[0], 1'b1}; pc_next = cnt1(phase_reg);
                        st_next = ST_RA_B;
                    end
                    ST_RA_B:
                    begin
                        ld_next = {ld_reg[1], 1'b0}; pc_next = cnt1(phase_reg);
                        st_next = ST_RA_C;
                    end
                    ST_RA_C:
                    begin
                        ld_next = 2'b01; pc_next = 8'd0;
                        o_rv = 1'b1; o_rb = sh_reg;
                        o_last = (op_reg == OP_EE_BURST) && (rem_reg == 16'd1);
                        nextp = 1'b1;
                    end
                    default: ;
                endcase
                // move to the next primitive of the plan
                if (nextp)
                begin
                    st_next = ST_FETCH;
                    if (op_reg == OP_EE_WRITE && pp_reg == 4'd7)
                        pp_next = (o_av ? o_ar : ab_reg) ? 4'd6 : 4'd8;
                    else if (op_reg == OP_EE_BURST && pp_reg == 4'd6)
                    begin
                        rem_next = rem_reg - 16'd1;
                        pp_next = (rem_reg != 16'd1) ? 4'd6 : 4'd7;
                    end
                    else
                        pp_next = pp_reg + 4'd1;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg <= 7'h50; phase_reg <= 8'd10; setup_reg <= 8'd50; stopt_reg <= 8'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE: dev_reg   <= cfg_data[6:0];
                CFG_PHASE:  phase_reg <= cfg_data;
                CFG_SETUP:  setup_reg <= cfg_data;
                CFG_STOP:   stopt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register, sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0; out_valid_reg <= 1'b0;
            st_reg <= ST_IDLE; pc_reg <= 8'd0; bc_reg <= 4'd0; sh_reg <= 8'd0;
            addr_reg <= 16'd0; rem_reg <= 16'd0; op_reg <= 3'd0; ld_reg <= 2'd0;
            pp_reg <= 4'd0; dh_reg <= 8'd0; ah_reg <= 1'b0; ab_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg <= st_next; pc_reg <= pc_next; bc_reg <= bc_next; sh_reg <= sh_next;
                addr_reg <= addr_next; rem_reg <= rem_next; op_reg <= op_next;
                ld_reg <= ld_next; pp_reg <= pp_next; dh_reg <= dh_next;
                ah_reg <= ah_next; ab_reg <= ab_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_func_reg <= s_tuser;
        end
        if (advance)
        begin
            out_data_reg <= {1'b0, o_done, o_ar, o_av, o_rb, o_rv,
                             st_next != ST_IDLE, ld_next[1], ld_next[0]};
            out_last_reg <= o_last;
        end
    end

endmodule
